// ===== rtl/hcmm_pkg.sv =====
package hcmm_pkg;

	// Bank geometry of the work RAM.
	localparam int BANK_COUNT_DEF = 8;
	localparam int BANK_BYTES     = 4096;
	localparam int OFS_W          = $clog2(BANK_BYTES);

	// Route codes of a result.
	localparam logic [2:0] RT_LOCAL   = 3'd0;
	localparam logic [2:0] RT_CART    = 3'd1;
	localparam logic [2:0] RT_JOY     = 3'd2;
	localparam logic [2:0] RT_UNIMPL  = 3'd3;
	localparam logic [2:0] RT_INVALID = 3'd4;

	// Access codes.
	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	// Register masks in the I/O page.
	localparam logic [7:0] SPEED_RD_MASK = 8'b1000_0001;
	localparam logic [7:0] IR_RD_MASK    = 8'b1100_0011;
	localparam logic [7:0] IR_WR_MASK    = 8'b1100_0001;
	localparam logic [2:0] BANK_SEL_MASK = 3'b111;

	// Decoded register targets.
	localparam logic [3:0] TG_NONE   = 4'd0;
	localparam logic [3:0] TG_RAM0   = 4'd1;
	localparam logic [3:0] TG_RAMX   = 4'd2;
	localparam logic [3:0] TG_IFLAG  = 4'd3;
	localparam logic [3:0] TG_SPEED  = 4'd4;
	localparam logic [3:0] TG_IR     = 4'd5;
	localparam logic [3:0] TG_EXTRA  = 4'd6;
	localparam logic [3:0] TG_BANK   = 4'd7;
	localparam logic [3:0] TG_IE     = 4'd8;

	typedef struct packed {
		logic        op;
		logic [15:0] address;
		logic [7:0]  write_data;
	} in_item_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic [2:0] route;
	} out_item_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic advance;
	} dp_cmd_t;

endpackage

// ===== rtl/hcmm_ctrl.sv =====
module hcmm_ctrl import hcmm_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	output dp_cmd_t cmd
);

	localparam logic ST_EMPTY = 1'b0;
	localparam logic ST_FULL  = 1'b1;

	logic st_q;
	logic out_valid_q;
	logic advance;
	logic accept;

	// The decode stage moves into the output register when that register is free or drains.
	assign advance   = (st_q == ST_FULL) && (!out_valid_q || out_ready);
	assign in_ready  = (st_q == ST_EMPTY) || advance;
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign cmd       = '{accept: accept, advance: advance};

	// Stage occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_EMPTY;
		end else begin
			unique case (st_q)
				ST_EMPTY: begin
					if (accept) st_q <= ST_FULL;
				end
				ST_FULL: begin
					if (advance && !accept) st_q <= ST_EMPTY;
				end
				default: st_q <= ST_EMPTY;
			endcase
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

`ifndef SYNTH
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_FULL && out_valid_q && !out_ready) |-> !in_ready)
		else $error("input taken while both stages are stalled");
	a_advance_loads: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("output register not loaded after advance");
	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (st_q == ST_FULL))
		else $error("accepted access lost from the decode stage");
`endif

endmodule

// ===== rtl/hcmm_datapath.sv =====
module hcmm_datapath import hcmm_pkg::*; #(
	parameter int BANK_COUNT = BANK_COUNT_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  dp_cmd_t   cmd,
	input  in_item_t  in_data,
	output out_item_t out_data
);

	localparam int BANK_AW = (BANK_COUNT > 1) ? $clog2(BANK_COUNT) : 1;
	localparam int RAM_AW  = BANK_AW + OFS_W;
	localparam int DEPTH   = BANK_COUNT * BANK_BYTES;

	logic [7:0]        mem [DEPTH];
	logic [2:0]        bank_select_q;
	logic              speed_q;
	logic [7:0]        ir_q;
	logic [7:0]        iflag_q;
	logic [7:0]        ie_q;
	logic [7:0]        extra_q [7];
	logic [2:0]        route;
	logic [3:0]        target;
	logic [2:0]        extra_idx;
	logic [2:0]        bank_wrapped;
	logic [RAM_AW-1:0] ram_idx;
	logic [7:0]        reg_rd;
	logic              is_wr;
	logic              ram_acc;
	logic [2:0]        route_s1;
	logic              sel_ram_s1;
	logic [7:0]        reg_data_s1;
	logic [7:0]        ram_data_s1;
	out_item_t         out_q;

	// Reduce the bank select to the banks that exist.
	function automatic logic [2:0] bank_wrap(input logic [2:0] b);
		logic [2:0] v;
		v = b;
		for (int k = 0; k < 4; k++) begin
			if (v >= 3'(BANK_COUNT)) v = v - 3'(BANK_COUNT);
		end
		return v;
	endfunction

	// Address decode in the priority order of the memory map.
	always_comb begin
		logic [15:0] a;
		a      = in_data.address;
		route  = RT_LOCAL;
		target = TG_NONE;
		if (a <= 16'h7FFF || (a >= 16'hA000 && a <= 16'hBFFF)) begin
			route = RT_CART;
		end else if (a <= 16'h9FFF) begin
			route = RT_UNIMPL;
		end else if (a <= 16'hCFFF) begin
			target = TG_RAM0;
		end else if (a <= 16'hDFFF) begin
			target = TG_RAMX;
		end else if (a <= 16'hFEFF) begin
			route = RT_UNIMPL;
		end else if (a == 16'hFF00) begin
			route = RT_JOY;
		end else if (a == 16'hFF0F) begin
			target = TG_IFLAG;
		end else if ((a >= 16'hFF01 && a <= 16'hFF02) || (a >= 16'hFF04 && a <= 16'hFF07)
				|| (a >= 16'hFF10 && a <= 16'hFF4B) || (a >= 16'hFF4F && a <= 16'hFF55)
				|| (a >= 16'hFF68 && a <= 16'hFF6B) || a == 16'hFF6F) begin
			route = RT_UNIMPL;
		end else if (a == 16'hFF4D) begin
			target = TG_SPEED;
		end else if (a == 16'hFF56) begin
			target = TG_IR;
		end else if (a == 16'hFF6C || (a >= 16'hFF72 && a <= 16'hFF77)) begin
			target = TG_EXTRA;
		end else if (a == 16'hFF70) begin
			target = TG_BANK;
		end else if (a <= 16'hFF7F) begin
			route = RT_INVALID;
		end else if (a <= 16'hFFFE) begin
			route = RT_UNIMPL;
		end else begin
			target = TG_IE;
		end
	end

	// Extra byte slot: the lone byte at the low address is slot zero.
	assign extra_idx = (in_data.address[7:0] == 8'h6C) ? 3'd0
		: 3'(in_data.address[2:0] - 3'd1);

	assign is_wr        = (in_data.op == OP_WRITE);
	assign ram_acc      = (target == TG_RAM0) || (target == TG_RAMX);
	assign bank_wrapped = bank_wrap(bank_select_q);
	assign ram_idx      = {(target == TG_RAMX) ? bank_wrapped[BANK_AW-1:0] : BANK_AW'(0),
		in_data.address[OFS_W-1:0]};

	// Register read selection.
	always_comb begin
		case (target)
			TG_IFLAG: reg_rd = iflag_q;
			TG_SPEED: reg_rd = {7'd0, speed_q} & SPEED_RD_MASK;
			TG_IR:    reg_rd = ir_q & IR_RD_MASK;
			TG_EXTRA: reg_rd = extra_q[extra_idx];
			TG_BANK:  reg_rd = {5'd0, bank_select_q & BANK_SEL_MASK};
			TG_IE:    reg_rd = ie_q;
			default:  reg_rd = 8'd0;
		endcase
	end

	// Work RAM: one write or one registered read per transfer.
	always_ff @(posedge clk) begin
		if (cmd.accept && ram_acc) begin
			if (is_wr) begin
				mem[ram_idx] <= in_data.write_data;
			end else begin
				ram_data_s1 <= mem[ram_idx];
			end
		end
	end

	// I/O page registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_select_q <= 3'd1;
			speed_q       <= 1'b0;
			ir_q          <= 8'd0;
			iflag_q       <= 8'd0;
			ie_q          <= 8'd0;
			for (int k = 0; k < 7; k++) extra_q[k] <= 8'd0;
		end else if (cmd.accept && is_wr) begin
			case (target)
				TG_IFLAG: iflag_q <= in_data.write_data;
				TG_SPEED: speed_q <= in_data.write_data[0];
				TG_IR:    ir_q <= (ir_q & ~IR_WR_MASK) | (in_data.write_data & IR_WR_MASK);
				TG_EXTRA: extra_q[extra_idx] <= in_data.write_data;
				TG_BANK: begin
					if ((in_data.write_data[2:0] & BANK_SEL_MASK) == 3'd0) bank_select_q <= 3'd1;
					else bank_select_q <= in_data.write_data[2:0] & BANK_SEL_MASK;
				end
				TG_IE:    ie_q <= in_data.write_data;
				default:  ;
			endcase
		end
	end

	// Decode stage.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			route_s1    <= route;
			sel_ram_s1  <= ram_acc && !is_wr;
			reg_data_s1 <= (is_wr || route != RT_LOCAL) ? 8'd0 : reg_rd;
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (cmd.advance) begin
			out_q.read_data <= sel_ram_s1 ? ram_data_s1 : reg_data_s1;
			out_q.route     <= route_s1;
		end
	end

	assign out_data = out_q;

`ifndef SYNTH
	a_bank_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		bank_select_q != 3'd0)
		else $error("bank select holds zero");
	a_fwd_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.accept && route != RT_LOCAL) |-> (target == TG_NONE))
		else $error("forwarded access also decoded to local storage");
	a_write_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.accept && is_wr) |=> (reg_data_s1 == 8'd0 && !sel_ram_s1))
		else $error("write access carries read data");
`endif

endmodule

// ===== rtl/handheld_console_memory_map.sv =====
// Each access passes the decode stage and then the output register before out_valid rises.
// Throughput: one access per cycle while out_ready does not stall the output register;
// decode stage and output register run overlapped.
// The work RAM is a single-port memory with registered read data, touched once per access.
// Reset clears the bank select to one and all I/O page registers to zero.
// Work RAM contents are undefined after reset until written.
module handheld_console_memory_map import hcmm_pkg::*; #(
	parameter int BANK_COUNT = BANK_COUNT_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	dp_cmd_t cmd;

	// Handshake control.
	hcmm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// Decode, storage and result path.
	hcmm_datapath #(
		.BANK_COUNT (BANK_COUNT)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_data  (in_data),
		.out_data (out_data)
	);

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps

module tb;
	import hcmm_pkg::*;

	localparam int RAM_BYTES     = BANK_COUNT_DEF * BANK_BYTES;
	localparam int QUIET_LIMIT   = 3000;
	localparam int SETTLE_CYCLES = 8;
	localparam int STALL_STRETCH = 300;

	// Bus addresses that the decoder treats specially.
	localparam logic [15:0] A_VRAM   = 16'h8000;
	localparam logic [15:0] A_CART_X = 16'hA000;
	localparam logic [15:0] A_RAM0   = 16'hC000;
	localparam logic [15:0] A_RAMX   = 16'hD000;
	localparam logic [15:0] A_ECHO   = 16'hE000;
	localparam logic [15:0] A_JOYPAD = 16'hFF00;
	localparam logic [15:0] A_IFLAG  = 16'hFF0F;
	localparam logic [15:0] A_SPEED  = 16'hFF4D;
	localparam logic [15:0] A_IR     = 16'hFF56;
	localparam logic [15:0] A_EXTRA0 = 16'hFF6C;
	localparam logic [15:0] A_BANK   = 16'hFF70;
	localparam logic [15:0] A_EXTRA1 = 16'hFF72;
	localparam logic [15:0] A_EXTRA6 = 16'hFF77;
	localparam logic [15:0] A_HRAM   = 16'hFF80;
	localparam logic [15:0] A_IE     = 16'hFFFF;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_data;

	// Shadow of the decoder state.
	logic [7:0] ram_bytes [RAM_BYTES];
	bit         ram_written [RAM_BYTES];
	logic [2:0] bank_sel = 3'd1;
	logic       speed_bit = 1'b0;
	logic [7:0] ir_reg = 8'h00;
	logic [7:0] iflag_reg = 8'h00;
	logic [7:0] ie_reg = 8'h00;
	logic [7:0] extra_regs [7] = '{default: 8'h00};

	out_item_t pending_results [$];
	int        mismatches = 0;
	int        quiet_cycles = 0;
	int        src_idle_pct;
	int        snk_stall_pct;
	int        hold_cycles;

	handheld_console_memory_map uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Physical work RAM byte that an address in C000-DFFF selects.
	function automatic int ram_index(input logic [15:0] a);
		if (a < A_RAMX) begin
			return int'(a[OFS_W-1:0]);
		end
		return (int'(bank_sel) % BANK_COUNT_DEF) * BANK_BYTES + int'(a[OFS_W-1:0]);
	endfunction

	function automatic bit io_unimplemented(input logic [15:0] a);
		return (a >= 16'hFF01 && a <= 16'hFF02) || (a >= 16'hFF04 && a <= 16'hFF07) ||
			(a >= 16'hFF10 && a <= 16'hFF4B) || (a >= 16'hFF4F && a <= 16'hFF55) ||
			(a >= 16'hFF68 && a <= 16'hFF6B) || a == 16'hFF6F;
	endfunction

	function automatic bit reads_unwritten_ram(input logic [15:0] a);
		return a >= A_RAM0 && a < A_ECHO && !ram_written[ram_index(a)];
	endfunction

	// Applies one access to the shadow state and returns the result it gives.
	function automatic out_item_t memory_map_access(input in_item_t acc);
		logic [15:0] a;
		logic [7:0]  d;
		logic        wr;
		int          idx;
		out_item_t   res;
		a = acc.address;
		d = acc.write_data;
		wr = (acc.op == OP_WRITE);
		res.read_data = 8'h00;
		res.route = RT_LOCAL;
		if (a < A_VRAM || (a >= A_CART_X && a < A_RAM0)) begin
			res.route = RT_CART;
		end else if (a < A_CART_X) begin
			res.route = RT_UNIMPL;
		end else if (a < A_ECHO) begin
			idx = ram_index(a);
			if (wr) begin
				ram_bytes[idx] = d;
				ram_written[idx] = 1'b1;
			end else begin
				res.read_data = ram_bytes[idx];
			end
		end else if (a < A_JOYPAD) begin
			res.route = RT_UNIMPL;
		end else if (a == A_JOYPAD) begin
			res.route = RT_JOY;
		end else if (a == A_IFLAG) begin
			if (wr) iflag_reg = d;
			else res.read_data = iflag_reg;
		end else if (io_unimplemented(a)) begin
			res.route = RT_UNIMPL;
		end else if (a == A_SPEED) begin
			if (wr) speed_bit = d[0];
			else res.read_data = {7'd0, speed_bit} & SPEED_RD_MASK;
		end else if (a == A_IR) begin
			if (wr) ir_reg = (ir_reg & ~IR_WR_MASK) | (d & IR_WR_MASK);
			else res.read_data = ir_reg & IR_RD_MASK;
		end else if (a == A_EXTRA0) begin
			if (wr) extra_regs[0] = d;
			else res.read_data = extra_regs[0];
		end else if (a == A_BANK) begin
			// A select of zero is stored as one.
			if (wr) bank_sel = ((d[2:0] & BANK_SEL_MASK) == 3'd0) ? 3'd1 : d[2:0];
			else res.read_data = {5'd0, bank_sel};
		end else if (a >= A_EXTRA1 && a <= A_EXTRA6) begin
			idx = int'(a - A_EXTRA1) + 1;
			if (wr) extra_regs[idx] = d;
			else res.read_data = extra_regs[idx];
		end else if (a < A_HRAM) begin
			res.route = RT_INVALID;
		end else if (a != A_IE) begin
			res.route = RT_UNIMPL;
		end else begin
			if (wr) ie_reg = d;
			else res.read_data = ie_reg;
		end
		return res;
	endfunction

	function automatic logic [15:0] pick_io_reg();
		case ($urandom_range(11))
			0: return A_IFLAG;
			1: return A_SPEED;
			2: return A_IR;
			3: return A_EXTRA0;
			4: return A_BANK;
			5: return A_IE;
			default: return A_EXTRA1 + 16'($urandom_range(5));
		endcase
	endfunction

	// Addresses beside the region boundaries.
	function automatic logic [15:0] pick_edge_addr();
		case ($urandom_range(39))
			0: return 16'h0000;   1: return 16'h7FFF;   2: return 16'h8000;
			3: return 16'h9FFF;   4: return 16'hA000;   5: return 16'hBFFF;
			6: return 16'hCFFF;   7: return 16'hD000;   8: return 16'hDFFF;
			9: return 16'hE000;   10: return 16'hFDFF;  11: return 16'hFE00;
			12: return 16'hFEFF;  13: return 16'hFF01;  14: return 16'hFF02;
			15: return 16'hFF03;  16: return 16'hFF04;  17: return 16'hFF07;
			18: return 16'hFF08;  19: return 16'hFF0E;  20: return 16'hFF10;
			21: return 16'hFF3F;  22: return 16'hFF40;  23: return 16'hFF4B;
			24: return 16'hFF4C;  25: return 16'hFF4E;  26: return 16'hFF4F;
			27: return 16'hFF55;  28: return 16'hFF57;  29: return 16'hFF67;
			30: return 16'hFF68;  31: return 16'hFF6B;  32: return 16'hFF6D;
			33: return 16'hFF6E;  34: return 16'hFF6F;  35: return 16'hFF71;
			36: return 16'hFF78;  37: return 16'hFF7F;  38: return 16'hFF80;
			default: return 16'hFFFE;
		endcase
	endfunction

	// Mostly RAM traffic and register accesses, with some bank switching and noise.
	function automatic in_item_t random_access();
		in_item_t acc;
		int       pick;
		acc.op = 1'($urandom_range(1));
		acc.address = 16'($urandom_range(16'hFFFF));
		acc.write_data = 8'($urandom_range(255));
		pick = $urandom_range(99);
		if (pick < 50) begin
			// A small window per bank so that reads often hit stored bytes.
			acc.op = (pick < 28) ? OP_WRITE : OP_READ;
			acc.address = A_RAM0 + 16'($urandom_range(1) << 12) +
				($urandom_range(1) ? 16'h0FC0 : 16'h0000) + 16'($urandom_range(63));
		end else if (pick < 62) begin
			acc.address = A_BANK;
			acc.op = ($urandom_range(4) != 0) ? OP_WRITE : OP_READ;
			if ($urandom_range(3) == 0) acc.write_data[2:0] = 3'd0;
		end else if (pick < 80) begin
			acc.address = pick_io_reg();
		end else if (pick < 90) begin
			acc.address = pick_edge_addr();
		end
		return acc;
	endfunction

	task automatic report_mismatch(input string field, input logic [7:0] got,
			input logic [7:0] want);
		$display("%0t: %s mismatch: got %0h, expected %0h", $realtime, field, got, want);
		mismatches++;
	endtask

	// Offers one access, waits for its transfer and records the result it must give.
	task automatic send_access(input logic op, input logic [15:0] address,
			input logic [7:0] data);
		in_item_t  acc;
		out_item_t res;
		acc.op = op;
		acc.address = address;
		acc.write_data = data;
		// Work RAM is never read before it has been stored.
		if (acc.op == OP_READ && reads_unwritten_ram(acc.address)) acc.op = OP_WRITE;
		while (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= acc;
		do @(posedge clk); while (!in_ready);
		res = memory_map_access(acc);
		pending_results.push_back(res);
	endtask

	task automatic send_random();
		in_item_t acc;
		acc = random_access();
		send_access(acc.op, acc.address, acc.write_data);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Reset values, the register masks and a zero bank select.
	task automatic test_registers();
		send_access(OP_READ, A_BANK, 8'h00);
		send_access(OP_READ, A_SPEED, 8'h00);
		send_access(OP_READ, A_IR, 8'h00);
		send_access(OP_READ, A_IE, 8'h00);
		send_access(OP_READ, A_IFLAG, 8'h00);
		send_access(OP_READ, A_EXTRA6, 8'h00);
		send_access(OP_WRITE, A_BANK, 8'h00);
		send_access(OP_READ, A_BANK, 8'h00);
		send_access(OP_WRITE, A_BANK, 8'hFF);
		send_access(OP_READ, A_BANK, 8'h00);
		send_access(OP_WRITE, A_SPEED, 8'hFF);
		send_access(OP_READ, A_SPEED, 8'h00);
		send_access(OP_WRITE, A_IR, 8'hFF);
		send_access(OP_READ, A_IR, 8'h00);
		send_access(OP_WRITE, A_IR, 8'h3E);
		send_access(OP_READ, A_IR, 8'h00);
	endtask

	// Work RAM extremes, forwarded accesses, unimplemented and unrouted addresses.
	task automatic test_region_decode();
		send_access(OP_WRITE, A_RAM0, 8'hFF);
		send_access(OP_READ, A_RAM0, 8'h00);
		send_access(OP_WRITE, 16'hDFFF, 8'hA5);
		send_access(OP_READ, 16'hDFFF, 8'hFF);
		send_access(OP_READ, 16'h0000, 8'h00);
		send_access(OP_WRITE, 16'h7FFF, 8'hFF);
		send_access(OP_WRITE, A_JOYPAD, 8'h30);
		send_access(OP_READ, 16'h9FFF, 8'h00);
		send_access(OP_WRITE, 16'hFF03, 8'hFF);
		send_access(OP_READ, 16'hFF7F, 8'h00);
		send_access(OP_WRITE, 16'hFFFE, 8'h55);
	endtask

	// Walks every bank select value, storing and reading back in the switched bank.
	task automatic test_bank_switching();
		logic [7:0]  sel;
		logic [15:0] a;
		logic [7:0]  data;
		for (int b = 0; b < 8; b++) begin
			sel = 8'($urandom_range(255));
			sel[2:0] = b[2:0];
			send_access(OP_WRITE, A_BANK, sel);
			send_access(OP_READ, A_BANK, 8'h00);
			for (int k = 0; k < 3; k++) begin
				a = (k == 0) ? A_RAMX : (k == 1) ? 16'hDFFF :
					A_RAMX + 16'($urandom_range(BANK_BYTES - 1));
				data = 8'($urandom_range(255));
				send_access(OP_WRITE, a, data);
				send_access(OP_READ, a, ~data);
			end
			send_access(OP_READ, A_RAM0 + 16'($urandom_range(BANK_BYTES - 1)), 8'h00);
		end
	endtask

	task automatic test_random_traffic(input int goal, input int idle_pct,
			input int stall_pct);
		src_idle_pct = idle_pct;
		snk_stall_pct = stall_pct;
		repeat (goal) send_random();
		wait_drained();
	endtask

	// The receiver holds off for a long stretch so that the block fills and stalls.
	task automatic test_output_backpressure();
		src_idle_pct = 0;
		snk_stall_pct = 0;
		hold_cycles = STALL_STRETCH;
		repeat (60) send_random();
		wait_drained();
	endtask

	// Receiver: random stalls, or a held-off stretch when one is requested.
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles--;
			out_ready <= 1'b0;
		end else if (snk_stall_pct == 0) begin
			out_ready <= 1'b1;
		end else begin
			out_ready <= ($urandom_range(99) >= snk_stall_pct);
		end
	end

	// Compares every result transfer with the oldest pending expectation.
	always @(posedge clk) begin : check_results
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unrequested result", out_data.read_data, 8'h00);
			end else begin
				want = pending_results.pop_front();
				if (out_data.read_data !== want.read_data)
					report_mismatch("read_data", out_data.read_data, want.read_data);
				if (out_data.route !== want.route)
					report_mismatch("route", {5'd0, out_data.route}, {5'd0, want.route});
			end
		end
	end

	// Ends the run when no transfer happens on either side for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
			else quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	initial begin
		in_valid = 1'b0;
		in_data = '0;
		arst_n = 1'b0;
		src_idle_pct = 0;
		snk_stall_pct = 0;
		hold_cycles = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_registers();
		test_region_decode();
		wait_drained();
		test_bank_switching();
		wait_drained();
		test_random_traffic(420, 0, 0);
		test_random_traffic(420, 71, 0);
		test_random_traffic(420, 0, 71);
		test_random_traffic(420, 37, 37);
		test_output_backpressure();

		wait_drained();
		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
